// File: sv/eva_pkg.sv
// Package for the 64-bit element-wise vector ALU: payload structs, codes,
// configuration view and the commands of the shared arithmetic unit.
// No dependencies; every other file of the block imports it.
`default_nettype none

package eva_pkg;

   localparam int DATA_WIDTH_DEF = 64;
   localparam int CNT_W          = 17;
   localparam int IDX_W          = 16;
   localparam int LEN_W          = 17;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;
   localparam logic [32:0] MAX_VECTOR_LENGTH = 33'd65536;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } eva_op_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_LENGTH   = 3'd1,
      STS_RANGE    = 3'd2,
      STS_DIVZERO  = 3'd3,
      STS_OVERFLOW = 3'd4
   } eva_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OP_SELECT     = 3'd0,
      REG_SCALAR_MODE   = 3'd1,
      REG_SCALAR_VALUE  = 3'd2,
      REG_RANGE_START   = 3'd3,
      REG_RANGE_END     = 3'd4,
      REG_SOURCE_LENGTH = 3'd5,
      REG_SECOND_LENGTH = 3'd6,
      REG_DEST_LENGTH   = 3'd7
   } eva_reg_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_DIV,
      CMD_FIX
   } eva_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX,
      ST_DONE
   } eva_state_type;

   typedef struct packed {
      logic signed [63:0] first_value;
      logic signed [63:0] second_value;
      logic               last_in;
   } eva_req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [IDX_W-1:0]   result_index;
      logic [2:0]         status;
      logic               last_out;
   } eva_rsp_type;

   typedef struct packed {
      eva_op_type       op_select;
      logic             scalar_mode;
      logic [IDX_W-1:0] range_start;
      logic [IDX_W-1:0] range_end;
      logic [LEN_W-1:0] source_length;
      logic [LEN_W-1:0] second_length;
      logic [LEN_W-1:0] dest_length;
   } eva_cfg_type;

   typedef struct packed {
      logic             valid;
      eva_status_type   status;
      logic [IDX_W-1:0] index;
      logic             last;
   } eva_fin_type;

endpackage

`default_nettype wire

// File: sv/eva_unit.sv
// Shared arithmetic unit: one adder/subtractor with its operand registers,
// stepped by the sequencer for add, subtract, shift-add multiply and
// restoring divide. Depends on eva_pkg.
`default_nettype none

module eva_unit #(
   parameter int DATA_WIDTH = eva_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire eva_pkg::eva_cmd_type    cmd,
   input  wire logic [DATA_WIDTH-1:0]   load_acc,
   input  wire logic [DATA_WIDTH-1:0]   load_mq,
   input  wire logic [DATA_WIDTH-1:0]   load_opb,
   input  wire logic                    load_neg,
   output logic      [DATA_WIDTH-1:0]   result
);
   import eva_pkg::*;

   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] mq_ff, mq_in;
   logic [DATA_WIDTH-1:0] opb_ff, opb_in;
   logic                  neg_ff, neg_in;

   logic [DATA_WIDTH:0]   add_x, add_y, add_sum;
   logic                  add_sub;

   // Adder operand selection.
   always_comb begin
      add_x   = {1'b0, acc_ff};
      add_y   = {1'b0, opb_ff};
      add_sub = 1'b0;
      case (cmd)
         CMD_SUB: begin
            add_sub = 1'b1;
         end
         CMD_MUL: begin
            add_y = mq_ff[0] ? {1'b0, opb_ff} : '0;
         end
         CMD_DIV: begin
            // Partial remainder shifted left with the next dividend bit.
            add_x   = {acc_ff, mq_ff[DATA_WIDTH-1]};
            add_sub = 1'b1;
         end
         CMD_FIX: begin
            add_x   = '0;
            add_y   = {1'b0, mq_ff};
            add_sub = neg_ff;
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + (DATA_WIDTH+1)'(add_sub);

   always_comb begin
      acc_in = acc_ff;
      mq_in  = mq_ff;
      opb_in = opb_ff;
      neg_in = neg_ff;
      case (cmd)
         CMD_LOAD: begin
            acc_in = load_acc;
            mq_in  = load_mq;
            opb_in = load_opb;
            neg_in = load_neg;
         end
         CMD_ADD, CMD_SUB, CMD_FIX: begin
            acc_in = add_sum[DATA_WIDTH-1:0];
         end
         CMD_MUL: begin
            acc_in = add_sum[DATA_WIDTH-1:0];
            opb_in = opb_ff << 1;
            mq_in  = mq_ff >> 1;
         end
         CMD_DIV: begin
            // A set top bit means the trial subtraction borrowed: keep the
            // shifted remainder and shift in a zero quotient bit.
            acc_in = add_sum[DATA_WIDTH] ? add_x[DATA_WIDTH-1:0]
                                         : add_sum[DATA_WIDTH-1:0];
            mq_in  = {mq_ff[DATA_WIDTH-2:0], ~add_sum[DATA_WIDTH]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mq_ff  <= mq_in;
      opb_ff <= opb_in;
      neg_ff <= neg_in;
   end

   assign result = acc_ff;

endmodule

`default_nettype wire

// File: sv/eva_seq.sv
// Sequencer: range and length checks, element counter, step counter and the
// state machine that drives the shared arithmetic unit. Depends on eva_pkg.
`default_nettype none

module eva_seq #(
   parameter int DATA_WIDTH = eva_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eva_pkg::eva_cfg_type cfg,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   input  wire logic                 div_zero,
   input  wire logic                 overflow,
   input  wire logic                 out_free,
   output logic                      req_stall,
   output eva_pkg::eva_cmd_type      cmd,
   output eva_pkg::eva_fin_type      fin
);
   import eva_pkg::*;

   localparam int SW = $clog2(DATA_WIDTH + 1);

   eva_state_type    state_ff, state_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [CNT_W-1:0] count_ff, count_in;
   eva_status_type   status_ff, status_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_ff, last_in;

   logic [IDX_W-1:0] idx_cur;
   logic             len_err, range_err, last_cur;
   eva_status_type   status_chk;

   assign idx_cur  = cfg.range_start + count_ff[IDX_W-1:0];
   assign last_cur = req_last || (idx_cur == cfg.range_end);

   assign len_err = (cfg.source_length != cfg.dest_length) ||
                    (!cfg.scalar_mode && (cfg.source_length != cfg.second_length));
   assign range_err = ({1'b0, cfg.range_end} >= cfg.source_length) ||
                      (33'(cfg.source_length) > MAX_VECTOR_LENGTH) ||
                      (cfg.range_start > cfg.range_end) ||
                      (idx_cur > cfg.range_end);

   always_comb begin
      if (len_err) begin
         status_chk = STS_LENGTH;
      end else if (range_err) begin
         status_chk = STS_RANGE;
      end else if ((cfg.op_select == OP_DIV) && div_zero) begin
         status_chk = STS_DIVZERO;
      end else if ((cfg.op_select == OP_DIV) && overflow) begin
         status_chk = STS_OVERFLOW;
      end else begin
         status_chk = STS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      cmd          = CMD_HOLD;
      fin.valid    = 1'b0;
      fin.status   = status_ff;
      fin.index    = idx_ff;
      fin.last     = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd       = CMD_LOAD;
               status_in = status_chk;
               idx_in    = idx_cur;
               last_in   = last_cur;
               count_in  = last_cur ? '0 : count_ff + CNT_W'(1);
               if (status_chk != STS_OK) begin
                  // Errors and the overflow case need no arithmetic.
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RUN;
                  if ((cfg.op_select == OP_ADD) || (cfg.op_select == OP_SUB)) begin
                     step_in = SW'(1);
                  end else begin
                     step_in = SW'(DATA_WIDTH);
                  end
               end
            end
         end
         ST_RUN: begin
            case (cfg.op_select)
               OP_ADD:  cmd = CMD_ADD;
               OP_SUB:  cmd = CMD_SUB;
               OP_MUL:  cmd = CMD_MUL;
               OP_DIV:  cmd = CMD_DIV;
               default: cmd = CMD_HOLD;
            endcase
            step_in = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               state_in = (cfg.op_select == OP_DIV) ? ST_FIX : ST_DONE;
            end
         end
         ST_FIX: begin
            // Apply the quotient sign.
            cmd      = CMD_FIX;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               fin.valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      idx_ff    <= idx_in;
      last_ff   <= last_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: sv/int64_vector_elementwise_alu.sv
// Top level of the 64-bit element-wise vector ALU: configuration registers,
// operand preparation and the result register. Uses eva_pkg, eva_seq, eva_unit.
//
// Usage: write the configuration registers through the csr_ port while the
// block is idle, then send the elements of the range in order on the req_
// channel (valid/stall). Each element gives one result on the rsp_ channel
// with its destination index, a status code and a last flag; the element
// counter returns to zero after a result flagged last.
// One element is worked on at a time and req_stall is high until its result
// has moved into the output register. A length, range, divide-by-zero or
// overflow result needs no arithmetic; add and subtract take one adder
// step, multiply one shift-add per bit and divide one restoring step per
// bit and a sign fix, all through the one shared adder. The next element
// can be taken once the result has entered the output register.
// While the receiver stalls, the result stays in the output register; a
// finished element waits in the sequencer until that register is free.
// Reset (synchronous) clears all configuration registers, the element
// counter, the sequencer and rsp_valid.
`default_nettype none

module int64_vector_elementwise_alu #(
   parameter int DATA_WIDTH = eva_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire eva_pkg::eva_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output eva_pkg::eva_rsp_type                     rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [eva_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [eva_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import eva_pkg::*;

   localparam logic [DATA_WIDTH-1:0] MIN_W = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   eva_op_type       op_select_ff;
   logic             scalar_mode_ff;
   logic [63:0]      scalar_value_ff;
   logic [IDX_W-1:0] range_start_ff, range_end_ff;
   logic [LEN_W-1:0] source_length_ff, second_length_ff, dest_length_ff;

   eva_cfg_type           cfg;
   eva_cmd_type           cmd;
   eva_fin_type           fin;
   logic                  out_free;

   logic [63:0]           b_src;
   logic [DATA_WIDTH-1:0] a_w, b_w, a_mag, b_mag, unit_result;
   logic [DATA_WIDTH-1:0] load_acc, load_mq, load_opb;
   logic                  div_zero, overflow;

   logic                  rsp_valid_ff, rsp_valid_in;
   eva_rsp_type           rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_select_ff     <= OP_ADD;
         scalar_mode_ff   <= 1'b0;
         scalar_value_ff  <= '0;
         range_start_ff   <= '0;
         range_end_ff     <= '0;
         source_length_ff <= '0;
         second_length_ff <= '0;
         dest_length_ff   <= '0;
      end else if (csr_we) begin
         case (eva_reg_type'(csr_index))
            REG_OP_SELECT:     op_select_ff     <= eva_op_type'(csr_wdata[1:0]);
            REG_SCALAR_MODE:   scalar_mode_ff   <= csr_wdata[0];
            REG_SCALAR_VALUE:  scalar_value_ff  <= csr_wdata;
            REG_RANGE_START:   range_start_ff   <= csr_wdata[IDX_W-1:0];
            REG_RANGE_END:     range_end_ff     <= csr_wdata[IDX_W-1:0];
            REG_SOURCE_LENGTH: source_length_ff <= csr_wdata[LEN_W-1:0];
            REG_SECOND_LENGTH: second_length_ff <= csr_wdata[LEN_W-1:0];
            REG_DEST_LENGTH:   dest_length_ff   <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.op_select     = op_select_ff;
      cfg.scalar_mode   = scalar_mode_ff;
      cfg.range_start   = range_start_ff;
      cfg.range_end     = range_end_ff;
      cfg.source_length = source_length_ff;
      cfg.second_length = second_length_ff;
      cfg.dest_length   = dest_length_ff;
   end

   // Operands are the low DATA_WIDTH bits, read as two's complement.
   assign b_src    = scalar_mode_ff ? scalar_value_ff : req_data.second_value;
   assign a_w      = req_data.first_value[DATA_WIDTH-1:0];
   assign b_w      = b_src[DATA_WIDTH-1:0];
   assign a_mag    = a_w[DATA_WIDTH-1] ? (~a_w + DATA_WIDTH'(1)) : a_w;
   assign b_mag    = b_w[DATA_WIDTH-1] ? (~b_w + DATA_WIDTH'(1)) : b_w;
   assign div_zero = (b_w == '0);
   assign overflow = (a_w == MIN_W) && (b_w == '1);

   always_comb begin
      load_acc = '0;
      load_mq  = b_w;
      load_opb = b_w;
      case (op_select_ff)
         OP_ADD, OP_SUB: begin
            load_acc = a_w;
         end
         OP_MUL: begin
            load_opb = a_w;
         end
         OP_DIV: begin
            load_mq  = a_mag;
            load_opb = b_mag;
         end
         default: begin
         end
      endcase
   end

   eva_seq #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_last  (req_data.last_in),
      .div_zero  (div_zero),
      .overflow  (overflow),
      .out_free  (out_free),
      .req_stall (req_stall),
      .cmd       (cmd),
      .fin       (fin)
   );

   eva_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_unit (
      .clock    (clock),
      .cmd      (cmd),
      .load_acc (load_acc),
      .load_mq  (load_mq),
      .load_opb (load_opb),
      .load_neg (a_w[DATA_WIDTH-1] ^ b_w[DATA_WIDTH-1]),
      .result   (unit_result)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (fin.valid) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.result_index  = fin.index;
         rsp_data_in.status        = fin.status;
         rsp_data_in.last_out      = fin.last;
         case (fin.status)
            STS_OK:       rsp_data_in.result_value = 64'(signed'(unit_result));
            STS_OVERFLOW: rsp_data_in.result_value = 64'(signed'(MIN_W));
            default:      rsp_data_in.result_value = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/eva_checker.sv
// Port-level checker for the element-wise vector ALU and the bind that
// attaches it to int64_vector_elementwise_alu. Depends on eva_pkg.
`default_nettype none

module eva_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire eva_pkg::eva_rsp_type               rsp_data
);
   import eva_pkg::*;

   // Only one element is in flight: a transfer closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an element was in flight");

   // A new result only appears after an element was being worked on.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an element in flight");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STS_OK) && (rsp_data.status != STS_OVERFLOW)
      |-> (rsp_data.result_value == '0))
      else $error("error result carries a nonzero value");

   a_overflow_negative: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STS_OVERFLOW) |-> rsp_data.result_value[63])
      else $error("overflow result is not the most negative value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind int64_vector_elementwise_alu eva_checker u_eva_checker (.*);

`default_nettype wire
